FILE: hdl/mak_pkg.sv
`timescale 1ns / 1ps
// Package for the modifier arrow key rewriter: byte codes and the burst type.
// It depends on nothing; the rewrite, serialiser and top-level files use it.
package mak_pkg;

    localparam int unsigned BURST_MAX = 6;

    localparam logic [7:0] ESC_BYTE      = 8'h1B;
    localparam logic [7:0] LBRACKET_BYTE = 8'h5B;
    localparam logic [7:0] SEMI_BYTE     = 8'h3B;
    localparam logic [7:0] TILDE_BYTE    = 8'h7E;
    localparam logic [7:0] ONE_CHAR      = 8'h31;
    localparam logic [7:0] SIX_CHAR      = 8'h36;
    localparam logic [7:0] A_CHAR        = 8'h41;
    localparam logic [7:0] D_CHAR        = 8'h44;
    localparam logic [7:0] ZERO_CHAR     = 8'h30;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [2:0]                count;
    } burst_t;

endpackage

FILE: hdl/mak_rewrite.sv
`timescale 1ns / 1ps
// Escape sequence matcher: holds the match phase and held digit, and turns one
// input byte into a burst of zero to six output bytes. Depends on mak_pkg.
module mak_rewrite (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  logic [7:0]      data_byte,
    input  logic [7:0]      modifier_bits,
    input  logic            end_of_chunk,
    output mak_pkg::burst_t burst
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_BRACKET,
        PH_DIGIT
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] digit_reg;
    logic [7:0] digit_next;
    logic [7:0] mod_char;
    logic [2:0] n;
    logic [mak_pkg::BURST_MAX-1:0][7:0] lst;

    always_comb begin
        logic [3:0] m;
        m = 4'd1;
        if (modifier_bits[0]) begin
            m = m + 4'd1;
        end
        if (modifier_bits[3]) begin
            m = m + 4'd2;
        end
        if (modifier_bits[2]) begin
            m = m + 4'd4;
        end
        mod_char = mak_pkg::ZERO_CHAR + {4'd0, m};
    end

    always_comb begin
        lst        = '0;
        n          = 3'd0;
        phase_next = phase_reg;
        digit_next = digit_reg;
        if (modifier_bits == 8'd0) begin
            if (phase_reg != PH_IDLE) begin
                lst[n] = mak_pkg::ESC_BYTE;
                n      = n + 3'd1;
            end
            if (phase_reg == PH_BRACKET || phase_reg == PH_DIGIT) begin
                lst[n] = mak_pkg::LBRACKET_BYTE;
                n      = n + 3'd1;
            end
            if (phase_reg == PH_DIGIT) begin
                lst[n] = digit_reg;
                n      = n + 3'd1;
            end
            lst[n]     = data_byte;
            n          = n + 3'd1;
            phase_next = PH_IDLE;
            digit_next = 8'd0;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    if (data_byte == mak_pkg::ESC_BYTE) begin
                        phase_next = PH_ESC;
                    end else begin
                        lst[n] = data_byte;
                        n      = n + 3'd1;
                    end
                end
                PH_ESC: begin
                    if (data_byte == mak_pkg::LBRACKET_BYTE) begin
                        phase_next = PH_BRACKET;
                    end else begin
                        lst[n] = mak_pkg::ESC_BYTE;
                        n      = n + 3'd1;
                        if (data_byte == mak_pkg::ESC_BYTE) begin
                            phase_next = PH_ESC;
                        end else begin
                            lst[n]     = data_byte;
                            n          = n + 3'd1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_BRACKET: begin
                    if (data_byte inside {[mak_pkg::A_CHAR:mak_pkg::D_CHAR]}) begin
                        lst[0]     = mak_pkg::ESC_BYTE;
                        lst[1]     = mak_pkg::LBRACKET_BYTE;
                        lst[2]     = mak_pkg::ONE_CHAR;
                        lst[3]     = mak_pkg::SEMI_BYTE;
                        lst[4]     = mod_char;
                        lst[5]     = data_byte;
                        n          = 3'd6;
                        phase_next = PH_IDLE;
                    end else if (data_byte inside
                                 {[mak_pkg::ONE_CHAR:mak_pkg::SIX_CHAR]}) begin
                        phase_next = PH_DIGIT;
                        digit_next = data_byte;
                    end else begin
                        lst[0] = mak_pkg::ESC_BYTE;
                        lst[1] = mak_pkg::LBRACKET_BYTE;
                        n      = 3'd2;
                        if (data_byte == mak_pkg::ESC_BYTE) begin
                            phase_next = PH_ESC;
                        end else begin
                            lst[n]     = data_byte;
                            n          = n + 3'd1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default: begin
                    digit_next = 8'd0;
                    lst[0]     = mak_pkg::ESC_BYTE;
                    lst[1]     = mak_pkg::LBRACKET_BYTE;
                    lst[2]     = digit_reg;
                    n          = 3'd3;
                    if (data_byte == mak_pkg::TILDE_BYTE) begin
                        lst[3]     = mak_pkg::SEMI_BYTE;
                        lst[4]     = mod_char;
                        lst[5]     = mak_pkg::TILDE_BYTE;
                        n          = 3'd6;
                        phase_next = PH_IDLE;
                    end else if (data_byte == mak_pkg::ESC_BYTE) begin
                        phase_next = PH_ESC;
                    end else begin
                        lst[n]     = data_byte;
                        n          = n + 3'd1;
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
        if (end_of_chunk) begin
            if (phase_next != PH_IDLE) begin
                lst[n] = mak_pkg::ESC_BYTE;
                n      = n + 3'd1;
            end
            if (phase_next == PH_BRACKET || phase_next == PH_DIGIT) begin
                lst[n] = mak_pkg::LBRACKET_BYTE;
                n      = n + 3'd1;
            end
            if (phase_next == PH_DIGIT) begin
                lst[n] = digit_next;
                n      = n + 3'd1;
            end
            phase_next = PH_IDLE;
            digit_next = 8'd0;
        end
    end

    assign burst.bytes = lst;
    assign burst.count = n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            digit_reg <= 8'd0;
        end else if (load) begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
        end
    end

endmodule

FILE: hdl/mak_serial.sv
`timescale 1ns / 1ps
// Output buffer that holds one burst and sends its bytes one transaction per
// cycle while m_tready is high, marking the final byte. Depends on mak_pkg.
module mak_serial (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  mak_pkg::burst_t burst,
    output logic            free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // out_byte[7:0]
    output logic            m_tlast    // last_of_run
);

    logic [mak_pkg::BURST_MAX-1:0][7:0] bytes_reg;
    logic [2:0] total_reg;
    logic [2:0] pos_reg;
    logic       busy_reg;
    logic       at_last;

    assign at_last  = (pos_reg == total_reg - 3'd1);
    assign free     = !busy_reg || (m_tready && at_last);
    assign m_tvalid = busy_reg;
    assign m_tdata  = bytes_reg[pos_reg];
    assign m_tlast  = at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            pos_reg   <= 3'd0;
            total_reg <= 3'd0;
        end else if (load) begin
            bytes_reg <= burst.bytes;
            total_reg <= burst.count;
            pos_reg   <= 3'd0;
            busy_reg  <= (burst.count != 3'd0);
        end else if (busy_reg && m_tready) begin
            if (at_last) begin
                busy_reg <= 1'b0;
            end else begin
                pos_reg <= pos_reg + 3'd1;
            end
        end
    end

endmodule

FILE: hdl/modifier_arrow_key_rewriter_core.sv
`timescale 1ns / 1ps
// Modifier arrow key rewriter top level: input register, sequence matcher and
// output buffer. Depends on mak_pkg, mak_rewrite and mak_serial.
// The first byte of an item passes the input register and then the output buffer.
// An item's output bytes leave one at a time on the single-byte output port; the
// input register can take the next item while the buffer still sends them.
// Reset (aresetn low, synchronous) empties both registers and clears the match.
module modifier_arrow_key_rewriter_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // data_byte[7:0]
    input  logic [7:0] s_tuser,    // modifier_bits[7:0]
    input  logic       s_tlast,    // end_of_chunk
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte[7:0]
    output logic       m_tlast     // last_of_run
);

    logic            in_valid_reg;
    logic [7:0]      data_reg;
    logic [7:0]      mods_reg;
    logic            eoc_reg;
    logic            free;
    logic            load;
    mak_pkg::burst_t burst;

    assign load     = in_valid_reg && free;
    assign s_tready = !in_valid_reg || free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
            data_reg     <= s_tdata;
            mods_reg     <= s_tuser;
            eoc_reg      <= s_tlast;
        end
    end

    mak_rewrite u_rewrite (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (load),
        .data_byte     (data_reg),
        .modifier_bits (mods_reg),
        .end_of_chunk  (eoc_reg),
        .burst         (burst)
    );

    mak_serial u_serial (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .burst    (burst),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
